// File: sv/blr_pkg.sv
// ---------------------------------------------------------------------------
// blr_pkg
// Shared types, constants and the microcode table of the line rasterizer.
// ---------------------------------------------------------------------------
package blr_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int GLYPH_BITS     = 8;
   localparam logic [GLYPH_BITS-1:0] GLYPH_RESET = 8'd32;

   // sequencer program counter, one value per microcode step
   typedef enum logic [0:0] {
      STEP_IDLE = 1'b0,
      STEP_EMIT = 1'b1
   } step_type;

   // jump conditions; taken -> target, else fall through to pc + 1
   typedef enum logic [0:0] {
      JC_NO_REQ       = 1'b0,
      JC_EMIT_PENDING = 1'b1
   } jcond_type;

   typedef struct packed {
      logic      accept;  // open input channel, load segment setup
      logic      emit;    // push a point and advance the line
      jcond_type cond;
      step_type  target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type pc);
      ctrl_word_type cw;
      unique case (pc)
         STEP_IDLE: cw = '{accept: 1'b1, emit: 1'b0, cond: JC_NO_REQ,
                           target: STEP_IDLE};
         STEP_EMIT: cw = '{accept: 1'b0, emit: 1'b1, cond: JC_EMIT_PENDING,
                           target: STEP_EMIT};
         default:   cw = '{accept: 1'b0, emit: 1'b0, cond: JC_NO_REQ,
                           target: STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// File: sv/bresenham_line_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Microcoded Bresenham rasterizer: one segment in, every raster point out.
// ---------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  req     | in        | valid / stall  | start_x, start_y, end_x, end_y
//  rsp     | out       | valid / stall  | point_x, point_y, point_glyph,
//          |           |                | visible, last_point
//  csr     | in        | valid / ready  | draw_glyph
//
//  A segment with major delta N yields N+1 points, one per cycle while rsp
//  is not stalled; each segment passes through the accept/setup step and then
//  one emit step per point.
//  Reset (synchronous) returns the sequencer to idle and the glyph to 32.
//  An rsp stall freezes the emit step; req is stalled outside idle.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer_unit #(
   parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // segment input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COORD_BITS-1:0]         req_start_x,
   input  logic [COORD_BITS-1:0]         req_start_y,
   input  logic [COORD_BITS-1:0]         req_end_x,
   input  logic [COORD_BITS-1:0]         req_end_y,
   // point output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COORD_BITS-1:0]         rsp_point_x,
   output logic [COORD_BITS-1:0]         rsp_point_y,
   output logic [blr_pkg::GLYPH_BITS-1:0] rsp_point_glyph,
   output logic                          rsp_visible,
   output logic                          rsp_last_point,
   // glyph register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [blr_pkg::GLYPH_BITS-1:0] csr_draw_glyph
);
   import blr_pkg::*;

   localparam int DW = COORD_BITS + 2;   // decision term, signed

   // sequencer
   step_type      pc_ff, pc_in;
   ctrl_word_type ctrl;
   logic          jump_taken;

   // datapath state
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [DW-1:0]         decision_ff, decision_in;
   logic [DW-1:0]         inc_straight_ff, inc_straight_in;
   logic [DW-1:0]         inc_diagonal_ff, inc_diagonal_in;
   logic [COORD_BITS-1:0] steps_left_ff, steps_left_in;
   logic                  x_neg_ff, x_neg_in;
   logic                  y_neg_ff, y_neg_in;
   logic                  major_x_ff, major_x_in;

   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [GLYPH_BITS-1:0] rsp_glyph_ff;
   logic                  rsp_vis_ff, rsp_last_ff;

   // setup terms
   logic                  in_x_neg, in_y_neg, in_major_x;
   logic [COORD_BITS-1:0] dx, dy, maj, mnr;
   logic [DW-1:0]         two_mnr, two_maj;

   logic req_accept, out_free, do_emit, diag, at_last;
   logic [COORD_BITS-1:0] x_step, y_step;

   assign ctrl       = ucode_rom(pc_ff);
   assign req_stall  = !ctrl.accept;
   assign req_accept = req_valid && ctrl.accept;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign do_emit    = ctrl.emit && out_free;
   assign at_last    = (steps_left_ff == '0);
   assign diag       = !decision_ff[DW-1] && (decision_ff != '0);
   assign csr_ready  = 1'b1;

   assign x_step = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
   assign y_step = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

   // segment setup from the input item
   always_comb begin
      in_x_neg   = req_end_x < req_start_x;
      in_y_neg   = req_end_y < req_start_y;
      dx         = in_x_neg ? req_start_x - req_end_x : req_end_x - req_start_x;
      dy         = in_y_neg ? req_start_y - req_end_y : req_end_y - req_start_y;
      in_major_x = dy <= dx;
      maj        = in_major_x ? dx : dy;
      mnr        = in_major_x ? dy : dx;
      two_mnr    = {1'b0, mnr, 1'b0};
      two_maj    = {1'b0, maj, 1'b0};
   end

   // next step
   always_comb begin
      unique case (ctrl.cond)
         JC_NO_REQ:       jump_taken = !req_valid;
         JC_EMIT_PENDING: jump_taken = !out_free || !at_last;
         default:         jump_taken = 1'b0;
      endcase
      pc_in = jump_taken ? ctrl.target : step_type'(pc_ff + 1'b1);
   end

   // datapath
   always_comb begin
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      decision_in     = decision_ff;
      inc_straight_in = inc_straight_ff;
      inc_diagonal_in = inc_diagonal_ff;
      steps_left_in   = steps_left_ff;
      x_neg_in        = x_neg_ff;
      y_neg_in        = y_neg_ff;
      major_x_in      = major_x_ff;
      if (req_accept) begin
         cur_x_in        = req_start_x;
         cur_y_in        = req_start_y;
         decision_in     = two_mnr - {2'b00, maj};
         inc_straight_in = two_mnr;
         inc_diagonal_in = two_mnr - two_maj;
         steps_left_in   = maj;
         x_neg_in        = in_x_neg;
         y_neg_in        = in_y_neg;
         major_x_in      = in_major_x;
      end else if (do_emit && !at_last) begin
         decision_in   = decision_ff + (diag ? inc_diagonal_ff : inc_straight_ff);
         steps_left_in = steps_left_ff - 1'b1;
         if (major_x_ff) begin
            cur_x_in = x_step;
            if (diag) begin
               cur_y_in = y_step;
            end
         end else begin
            cur_y_in = y_step;
            if (diag) begin
               cur_x_in = x_step;
            end
         end
      end
   end

   always_comb begin
      glyph_in = glyph_ff;
      if (csr_valid && csr_ready) begin
         glyph_in = csr_draw_glyph;
      end
      rsp_valid_in = rsp_valid_ff;
      if (do_emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         glyph_ff     <= GLYPH_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         glyph_ff     <= glyph_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      decision_ff     <= decision_in;
      inc_straight_ff <= inc_straight_in;
      inc_diagonal_ff <= inc_diagonal_in;
      steps_left_ff   <= steps_left_in;
      x_neg_ff        <= x_neg_in;
      y_neg_ff        <= y_neg_in;
      major_x_ff      <= major_x_in;
      if (do_emit) begin
         rsp_x_ff     <= cur_x_ff;
         rsp_y_ff     <= cur_y_ff;
         rsp_glyph_ff <= glyph_ff;
         rsp_vis_ff   <= (cur_x_ff != '0) && (cur_y_ff != '0);
         rsp_last_ff  <= at_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_glyph = rsp_glyph_ff;
   assign rsp_visible     = rsp_vis_ff;
   assign rsp_last_point  = rsp_last_ff;

   // an accepted segment always moves the sequencer into the emit step
   a_accept_to_emit: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pc_ff == STEP_EMIT)
      else $error("accepted segment did not start emitting");

   // the last point of a segment returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (do_emit && at_last) |=> (pc_ff == STEP_IDLE && rsp_last_point))
      else $error("last point did not end the segment");

   // a blocked emit step must not advance the line
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_EMIT && !do_emit) |=>
         ($stable(steps_left_ff) && $stable(cur_x_ff) && $stable(cur_y_ff)))
      else $error("line advanced while output was blocked");

   // a new point is only loaded when the previous one left or none was held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !do_emit)
      else $error("pending point overwritten");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: line rasterizer testbench
// Sends line segments through the req channel in random bursts, collects
// every raster point from rsp under a shifting stall pattern, and checks
// each point against a Bresenham predictor. The glyph register is
// rewritten between phases while the unit is idle.
// ---------------------------------------------------------------------------
module tb;
   import blr_pkg::*;

   localparam int CB          = COORD_BITS_DEF;
   localparam int CMAX        = (1 << CB) - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct packed {
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic [GLYPH_BITS-1:0] glyph;
      logic                  visible;
      logic                  last;
   } raster_point_type;

   // predicts the raster points of each accepted segment and checks them
   class line_point_checker;
      raster_point_type      expected_points[$];
      logic [GLYPH_BITS-1:0] glyph;
      logic [CB-1:0]         cur_x, cur_y;
      int                    decision, inc_straight, inc_diag, steps_left;
      bit                    x_neg, y_neg, major_x;
      int                    errors;

      function new();
         glyph        = GLYPH_RESET;
         cur_x        = '0;
         cur_y        = '0;
         decision     = 0;
         inc_straight = 0;
         inc_diag     = 0;
         steps_left   = 0;
         x_neg        = 1'b0;
         y_neg        = 1'b0;
         major_x      = 1'b0;
         errors       = 0;
      endfunction

      function void set_glyph(logic [GLYPH_BITS-1:0] g);
         glyph = g;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      task report(string msg);
         if (errors < 40) begin
            $display("ERROR @%0t: %s", $realtime, msg);
         end
         errors++;
      endtask

      function logic [CB-1:0] step_coord(logic [CB-1:0] v, bit neg);
         return neg ? v - 1'b1 : v + 1'b1;
      endfunction

      function void push_point();
         raster_point_type p;
         p.x       = cur_x;
         p.y       = cur_y;
         p.glyph   = glyph;
         p.visible = (cur_x != 0) && (cur_y != 0);
         p.last    = (steps_left == 0);
         expected_points.push_back(p);
      endfunction

      function void note_segment(logic [CB-1:0] x0, logic [CB-1:0] y0,
                                 logic [CB-1:0] x1, logic [CB-1:0] y1);
         int dx, dy, maj, mnr;
         bit diag;
         x_neg   = x1 < x0;
         y_neg   = y1 < y0;
         dx      = x_neg ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
         dy      = y_neg ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
         // ties go to x
         major_x = dy <= dx;
         maj     = major_x ? dx : dy;
         mnr     = major_x ? dy : dx;
         decision     = 2 * mnr - maj;
         inc_straight = 2 * mnr;
         inc_diag     = 2 * (mnr - maj);
         steps_left   = maj;
         cur_x = x0;
         cur_y = y0;
         push_point();
         while (steps_left > 0) begin
            diag = decision > 0;
            decision += diag ? inc_diag : inc_straight;
            if (major_x) begin
               cur_x = step_coord(cur_x, x_neg);
               if (diag) cur_y = step_coord(cur_y, y_neg);
            end else begin
               cur_y = step_coord(cur_y, y_neg);
               if (diag) cur_x = step_coord(cur_x, x_neg);
            end
            steps_left--;
            push_point();
         end
      endfunction

      task check_point(raster_point_type got);
         raster_point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("unexpected point (%0d,%0d)", got.x, got.y));
            return;
         end
         want = expected_points.pop_front();
         if (got.x !== want.x)
            report($sformatf("point_x %0d, want %0d", got.x, want.x));
         if (got.y !== want.y)
            report($sformatf("point_y %0d, want %0d", got.y, want.y));
         if (got.glyph !== want.glyph)
            report($sformatf("point_glyph %0d, want %0d", got.glyph, want.glyph));
         if (got.visible !== want.visible)
            report($sformatf("visible %b, want %b at (%0d,%0d)",
                             got.visible, want.visible, want.x, want.y));
         if (got.last !== want.last)
            report($sformatf("last_point %b, want %b at (%0d,%0d)",
                             got.last, want.last, want.x, want.y));
      endtask
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [CB-1:0]         req_start_x    = '0;
   logic [CB-1:0]         req_start_y    = '0;
   logic [CB-1:0]         req_end_x      = '0;
   logic [CB-1:0]         req_end_y      = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [CB-1:0]         rsp_point_x;
   logic [CB-1:0]         rsp_point_y;
   logic [GLYPH_BITS-1:0] rsp_point_glyph;
   logic                  rsp_visible;
   logic                  rsp_last_point;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [GLYPH_BITS-1:0] csr_draw_glyph = '0;

   line_point_checker sb;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int mode_left   = 0;

   bresenham_line_rasterizer_unit #(.COORD_BITS(CB)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_glyph (rsp_point_glyph),
      .rsp_visible     (rsp_visible),
      .rsp_last_point  (rsp_last_point),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_draw_glyph  (csr_draw_glyph)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver stall: modes of free flow, sparse, heavy and periodic stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(40, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
         default: begin
            rsp_stall <= ((mode_left % 7) < 3);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_point('{x: rsp_point_x, y: rsp_point_y, glyph: rsp_point_glyph,
                          visible: rsp_visible, last: rsp_last_point});
      end
   end

   function automatic logic [CB-1:0] clip(int v);
      if (v < 0) return '0;
      if (v > CMAX) return CMAX[CB-1:0];
      return v[CB-1:0];
   endfunction

   task automatic push_segment(int x0, int y0, int x1, int y1);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_valid   <= 1'b1;
      req_start_x <= clip(x0);
      req_start_y <= clip(y0);
      req_end_x   <= clip(x1);
      req_end_y   <= clip(y1);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_segment(clip(x0), clip(y0), clip(x1), clip(y1));
      burst_left--;
   endtask

   task automatic drain_points();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_glyph(logic [GLYPH_BITS-1:0] g);
      csr_valid      <= 1'b1;
      csr_draw_glyph <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_glyph(g);
      @(posedge clock);
   endtask

   task automatic random_segment();
      int kind, x0, y0, d;
      kind = $urandom_range(0, 99);
      x0   = $urandom_range(0, CMAX);
      y0   = $urandom_range(0, CMAX);
      if (kind < 55) begin
         push_segment(x0, y0, $urandom_range(0, CMAX), $urandom_range(0, CMAX));
      end else if (kind < 72) begin
         // short segment around the start point
         push_segment(x0, y0, x0 + $urandom_range(0, 8) - 4,
                      y0 + $urandom_range(0, 8) - 4);
      end else if (kind < 80) begin
         push_segment(x0, y0, x0, y0);
      end else if (kind < 92) begin
         // diagonal, horizontal or vertical
         d = $urandom_range(0, CMAX) - x0;
         case ($urandom_range(0, 3))
            0: push_segment(x0, y0, x0 + d, y0 + d);
            1: push_segment(x0, y0, x0 + d, y0 - d);
            2: push_segment(x0, y0, x0 + d, y0);
            default: push_segment(x0, y0, x0, $urandom_range(0, CMAX));
         endcase
      end else begin
         // segments starting on a zero coordinate and ending near the other axis
         if ($urandom_range(0, 1) == 1)
            push_segment(0, y0, $urandom_range(0, CMAX), $urandom_range(0, 2));
         else
            push_segment(x0, 0, $urandom_range(0, 2), $urandom_range(0, CMAX));
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, full-range diagonals, axes, all octants
      push_segment(0, 0, 0, 0);
      push_segment(CMAX, CMAX, CMAX, CMAX);
      push_segment(5, 5, 5, 5);
      push_segment(0, 0, CMAX, CMAX);
      push_segment(CMAX, CMAX, 0, 0);
      push_segment(0, CMAX, CMAX, 0);
      push_segment(CMAX, 0, 0, CMAX);
      push_segment(0, 10, CMAX, 10);
      push_segment(CMAX, 10, 0, 10);
      push_segment(10, 0, 10, CMAX);
      push_segment(10, CMAX, 10, 0);
      push_segment(32, 32, 62, 39);
      push_segment(32, 32, 39, 62);
      push_segment(32, 32, 2, 39);
      push_segment(32, 32, 25, 62);
      push_segment(32, 32, 2, 25);
      push_segment(32, 32, 25, 2);
      push_segment(32, 32, 62, 25);
      push_segment(32, 32, 39, 2);
      push_segment(3, 0, 0, 3);
      drain_points();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_glyph('0);
            1: write_glyph('1);
            5: write_glyph(GLYPH_RESET);
            default: write_glyph(GLYPH_BITS'($urandom_range(0, 255)));
         endcase
         repeat (50) random_segment();
         drain_points();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending() > 0) sb.report($sformatf("%0d points never seen", sb.pending()));
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/blr_pkg.sv
sv/bresenham_line_rasterizer_unit.sv
dv/tb.sv
